FILE: rtl/psa_pkg.sv
// Types and constants shared by the id/slot allocator modules.
package psa_pkg;

    localparam int ID_W     = 8;
    localparam int SLOT_W   = 5;
    localparam int CFG_W    = 32;
    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 3'd0,
        ST_RELEASED  = 3'd1,
        ST_NO_TABLE  = 3'd2,
        ST_EXHAUSTED = 3'd3,
        ST_NEW_SLOT  = 3'd4
    } psa_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_BUILD,
        S_SCAN,
        S_CLEAR,
        S_RELEASE
    } psa_state_t;

    typedef struct packed {
        logic              mode;
        logic [ID_W-1:0]   id_number;
        logic [SLOT_W-1:0] slot;
    } psa_item_t;

    typedef struct packed {
        psa_status_t       status;
        logic [ID_W-1:0]   id_number_out;
        logic [SLOT_W-1:0] slot_out;
    } psa_result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic        accept;
        logic        build_init;
        logic        build_step;
        logic        build_done;
        logic        scan_init;
        logic        scan_read;
        logic        take;
        logic        clear_init;
        logic        clear_step;
        logic        rel_read;
        logic        rel_write;
        logic        emit;
        psa_status_t emit_status;
    } psa_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_release;
        logic built;
        logic rel_ok;
        logic cnt_zero;
        logic cnt_done;
        logic word_free;
        logic fresh_none;
        logic all_active;
    } psa_stat_t;

endpackage

FILE: rtl/psa_datapath.sv
// Datapath: id table memory, scan counters, slot registers and result register.
module psa_datapath
    import psa_pkg::*;
#(
    parameter int NUM_IDS   = 256,
    parameter int NUM_SLOTS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  psa_item_t        item,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    input  psa_cmd_t         cmd,
    output psa_stat_t        stat,
    output logic             done,
    output psa_result_t      result
);

    localparam int IDX_W = $clog2(NUM_IDS);
    localparam int CNT_W = IDX_W + 1;

    logic [NUM_SLOTS-1:0] mem [NUM_IDS];

    psa_item_t            item_reg;
    logic [CFG_W-1:0]     active_reg;
    logic [NUM_SLOTS-1:0] known_reg;
    logic [NUM_SLOTS-1:0] fresh_reg;
    logic                 built_reg;
    logic [IDX_W-1:0]     start_reg;
    logic [IDX_W-1:0]     addr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     last_addr_reg;
    logic [NUM_SLOTS-1:0] rd_data_reg;
    logic                 done_reg;
    psa_result_t          result_reg;

    logic [NUM_SLOTS-1:0] act;
    logic [NUM_SLOTS-1:0] fresh;
    logic [NUM_SLOTS-1:0] slot_onehot;
    logic [NUM_SLOTS-1:0] low_onehot;
    logic [SLOT_W-1:0]    low_idx;
    logic                 cnt_done;
    logic                 advance;
    logic [IDX_W-1:0]     addr_inc;
    logic [IDX_W-1:0]     last_inc;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [NUM_SLOTS-1:0] wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;

    function automatic logic [SLOT_W-1:0] lowest_clear(input logic [NUM_SLOTS-1:0] w);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!w[i])
            begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] r;
        if (a == IDX_W'(NUM_IDS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = a + 1'b1;
        end
        return r;
    endfunction

    assign act         = active_reg[NUM_SLOTS-1:0];
    assign fresh       = act & ~known_reg;
    assign slot_onehot = NUM_SLOTS'(1) << item_reg.slot;
    assign low_idx     = lowest_clear(rd_data_reg);
    assign low_onehot  = NUM_SLOTS'(1) << low_idx;
    assign cnt_done    = (cnt_reg == CNT_W'(NUM_IDS));
    assign addr_inc    = wrap_inc(addr_reg);
    assign last_inc    = wrap_inc(last_addr_reg);

    assign advance = !cnt_done && (cmd.build_step || cmd.scan_read || cmd.clear_step);

    assign stat.is_release = item_reg.mode;
    assign stat.built      = built_reg;
    assign stat.rel_ok     = ({1'b0, item_reg.id_number} < (ID_W + 1)'(NUM_IDS))
                             && |(known_reg & slot_onehot);
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.cnt_done   = cnt_done;
    assign stat.word_free  = ~&rd_data_reg;
    assign stat.fresh_none = (fresh == '0);
    assign stat.all_active = &act;

    // Table write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = last_addr_reg;
        wr_data = rd_data_reg;
        if (cmd.build_step && !cnt_done)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_reg;
            wr_data = ~act;
        end
        else if (cmd.take)
        begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg | low_onehot;
        end
        else if (cmd.clear_step && cnt_reg != '0)
        begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg & ~fresh_reg;
        end
        else if (cmd.rel_write)
        begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg & ~slot_onehot;
        end
    end

    // Table read port
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = addr_reg;
        if ((cmd.scan_read || cmd.clear_step) && !cnt_done)
        begin
            rd_en = 1'b1;
        end
        else if (cmd.rel_read)
        begin
            rd_en   = 1'b1;
            rd_addr = item_reg.id_number[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg   <= mem[rd_addr];
            last_addr_reg <= rd_addr;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= item;
        end
        if (cmd.clear_init)
        begin
            fresh_reg <= fresh;
        end
        if (cmd.emit)
        begin
            result_reg.status        <= cmd.emit_status;
            result_reg.id_number_out <= cmd.take ? ID_W'(last_addr_reg) : '0;
            result_reg.slot_out      <= cmd.take ? low_idx : '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= CFG_W'(1);
            known_reg  <= '0;
            built_reg  <= 1'b0;
            start_reg  <= '0;
            addr_reg   <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cfg_we)
            begin
                active_reg <= cfg_data;
            end
            if (cmd.build_done)
            begin
                built_reg <= 1'b1;
                known_reg <= act;
            end
            else if (cmd.clear_init)
            begin
                known_reg <= known_reg | fresh;
            end
            if (cmd.take)
            begin
                start_reg <= last_inc;
            end
            if (cmd.build_init || cmd.clear_init)
            begin
                addr_reg <= '0;
                cnt_reg  <= '0;
            end
            else if (cmd.scan_init)
            begin
                addr_reg <= start_reg;
                cnt_reg  <= '0;
            end
            else if (advance)
            begin
                addr_reg <= addr_inc;
                cnt_reg  <= cnt_reg + 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: rtl/psa_controller.sv
// Controller: sequences build, scan, clear and release over the datapath.
module psa_controller
    import psa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  psa_stat_t stat,
    output logic      busy,
    output psa_cmd_t  cmd
);

    psa_state_t state_reg;
    psa_state_t state_next;
    logic       retried_reg;
    logic       retried_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            retried_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            retried_reg <= retried_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        retried_next = retried_reg;
        cmd          = '0;
        cmd.emit_status = ST_ALLOCATED;
        busy         = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_release)
                begin
                    if (!stat.built)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_NO_TABLE;
                        state_next      = S_IDLE;
                    end
                    else if (stat.rel_ok)
                    begin
                        cmd.rel_read = 1'b1;
                        state_next   = S_RELEASE;
                    end
                    else
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_RELEASED;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    retried_next = 1'b0;
                    if (!stat.built)
                    begin
                        cmd.build_init = 1'b1;
                        state_next     = S_BUILD;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_BUILD:
            begin
                if (!stat.cnt_done)
                begin
                    cmd.build_step = 1'b1;
                end
                else
                begin
                    cmd.build_done = 1'b1;
                    cmd.scan_init  = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // The word read last cycle is checked while the next is fetched
                if (!stat.cnt_zero && stat.word_free)
                begin
                    cmd.take        = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_ALLOCATED;
                    state_next      = S_IDLE;
                end
                else if (!stat.cnt_done)
                begin
                    cmd.scan_read = 1'b1;
                end
                else if (retried_reg)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_NEW_SLOT;
                    state_next      = S_IDLE;
                end
                else if (stat.fresh_none)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = stat.all_active ? ST_EXHAUSTED : ST_NEW_SLOT;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.clear_init = 1'b1;
                    state_next     = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.cnt_done)
                begin
                    cmd.scan_init = 1'b1;
                    retried_next  = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_RELEASE:
            begin
                cmd.rel_write   = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_RELEASED;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/proxy_id_slot_allocator.sv
// Top level of the round-robin id/slot allocator.
//
// An item is taken when start is high and busy is low; its result appears on
// result for one cycle with done high and must be taken then. A release passes
// from decode through the release state to done, or finishes at decode when the
// table is not yet built, the id is out of range or the slot is not yet known.
// An allocation scans table words from the round-robin start to the first word
// with a free slot, or all NUM_IDS words when none is free. The first
// allocation after reset builds the table first. When the scan finds nothing
// and newly active slots exist, a clearing pass and a second scan follow. The
// scan is paced by the table memory, which is read one word per cycle. busy
// drops in the cycle done is high, so the next item may be taken then.
// cfg_ready is always high.
module proxy_id_slot_allocator
    import psa_pkg::*;
#(
    parameter int NUM_IDS   = 256,
    parameter int NUM_SLOTS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  psa_item_t        item,
    output logic             done,
    output psa_result_t      result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    psa_cmd_t  cmd;
    psa_stat_t stat;

    assign cfg_ready = 1'b1;

    psa_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    psa_datapath #(
        .NUM_IDS   (NUM_IDS),
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .result   (result)
    );

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the round-robin id/slot allocator.
`timescale 1ns / 100ps

module testbench;
    import psa_pkg::*;

    localparam int ID_COUNT    = 1 << ID_W;
    localparam int CYCLE_LIMIT = 4_000_000;

    // Mirrors the allocation table and holds the answers still to come.
    class alloc_scoreboard;
        bit [CFG_W-1:0]         id_words [ID_COUNT];
        bit                     built;
        bit [CFG_W-1:0]         known;
        bit [CFG_W-1:0]         active;
        bit [ID_W-1:0]          next_id;
        psa_result_t            pending_answers[$];
        bit [ID_W+SLOT_W-1:0]   taken_pairs[$];
        psa_status_t            last_status;
        int                     mismatches;

        function new();
            active      = 32'h0000_0001;
            built       = 1'b0;
            known       = '0;
            next_id     = '0;
            mismatches  = 0;
            last_status = ST_ALLOCATED;
        endfunction

        function void set_active(bit [CFG_W-1:0] value);
            active = value;
        endfunction

        // Round-robin search from next_id for a word with a clear bit.
        function int find_free_word();
            bit [ID_W-1:0] idx;
            for (int i = 0; i < ID_COUNT; i++)
            begin
                idx = next_id + i[ID_W-1:0];
                if (id_words[idx] != '1)
                    return int'(idx);
            end
            return -1;
        endfunction

        function void note_item(psa_item_t it);
            psa_result_t    ans;
            bit [CFG_W-1:0] fresh;
            int             w;
            int             b;
            ans.status        = ST_ALLOCATED;
            ans.id_number_out = '0;
            ans.slot_out      = '0;
            if (it.mode)
            begin
                if (!built)
                    ans.status = ST_NO_TABLE;
                else
                begin
                    // a slot that never became known leaves the table alone
                    if (known[it.slot])
                        id_words[it.id_number][it.slot] = 1'b0;
                    ans.status = ST_RELEASED;
                end
            end
            else
            begin
                if (!built)
                begin
                    foreach (id_words[i])
                        id_words[i] = ~active;
                    known   = active;
                    next_id = '0;
                    built   = 1'b1;
                end
                w = find_free_word();
                if (w < 0)
                begin
                    fresh = active & ~known;
                    if (fresh == '0)
                        ans.status = (active == '1) ? ST_EXHAUSTED : ST_NEW_SLOT;
                    else
                    begin
                        // open the newly active slots in every word, then retry
                        known |= fresh;
                        foreach (id_words[i])
                            id_words[i] &= ~fresh;
                        w = find_free_word();
                        if (w < 0)
                            ans.status = ST_NEW_SLOT;
                    end
                end
                if (w >= 0)
                begin
                    next_id = w[ID_W-1:0] + 1'b1;
                    b = 0;
                    while (id_words[w][b])
                        b++;
                    id_words[w][b]    = 1'b1;
                    ans.id_number_out = w[ID_W-1:0];
                    ans.slot_out      = b[SLOT_W-1:0];
                    taken_pairs.push_back({ans.id_number_out, ans.slot_out});
                end
            end
            last_status = ans.status;
            pending_answers.push_back(ans);
        endfunction

        function void check_result(psa_result_t got);
            psa_result_t exp_ans;
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d id %0d slot %0d",
                             got.status, got.id_number_out, got.slot_out);
                return;
            end
            exp_ans = pending_answers.pop_front();
            if (got.status !== exp_ans.status ||
                got.id_number_out !== exp_ans.id_number_out ||
                got.slot_out !== exp_ans.slot_out)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: status %0d/%0d id %0d/%0d slot %0d/%0d (exp/got)",
                             exp_ans.status, got.status,
                             exp_ans.id_number_out, got.id_number_out,
                             exp_ans.slot_out, got.slot_out);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    psa_item_t        item;
    logic             done;
    psa_result_t      result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    alloc_scoreboard  sb = new();
    int               gap_pct;

    proxy_id_slot_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Check results before noting a new item: both can land on the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result);
            if (cfg_valid && cfg_ready)
                sb.set_active(cfg_data);
            if (start && !busy)
                sb.note_item(item);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("testbench: errors");
        $finish;
    end

    function automatic psa_item_t make_item(input logic mode_bit,
                                            input logic [ID_W-1:0] id_num,
                                            input logic [SLOT_W-1:0] sl);
        psa_item_t it;
        it.mode      = mode_bit;
        it.id_number = id_num;
        it.slot      = sl;
        return it;
    endfunction

    // Entered and left at a falling edge; busy is stable there.
    task automatic send_item(input psa_item_t it);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            item  <= make_item(1'($urandom), ID_W'($urandom), SLOT_W'($urandom));
            @(negedge clk);
        end
        start <= 1'b1;
        item  <= it;
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic send_alloc();
        send_item(make_item(1'b0, ID_W'($urandom), SLOT_W'($urandom)));
    endtask

    task automatic release_taken();
        int                   pick;
        bit [ID_W+SLOT_W-1:0] pair;
        pick = $urandom_range(sb.taken_pairs.size() - 1);
        pair = sb.taken_pairs[pick];
        sb.taken_pairs.delete(pick);
        send_item(make_item(1'b1, pair[SLOT_W +: ID_W], pair[SLOT_W-1:0]));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending_answers.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_active(input logic [CFG_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        while (!cfg_ready)
            @(negedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int count);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                send_alloc();
            else if (pick < 85 && sb.taken_pairs.size() != 0)
                release_taken();
            else
                send_item(make_item(1'b1, ID_W'($urandom), SLOT_W'($urandom)));
        end
    endtask

    task automatic fill_until(input psa_status_t stop_status, input int max_items);
        int n;
        n = 0;
        do
        begin
            send_alloc();
            n++;
        end
        while (sb.last_status != stop_status && n < max_items);
    endtask

    initial
    begin
        logic [CFG_W-1:0] cfg_word;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        gap_pct   = 33;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // releases with no table yet
        send_item(make_item(1'b1, '1, '1));
        send_item(make_item(1'b1, '0, '0));
        write_active('1);
        write_active(32'h0000_0001);
        repeat (3) send_alloc();
        send_item(make_item(1'b1, 8'd1, 5'd0));
        send_item(make_item(1'b1, 8'd255, 5'd31));
        send_item(make_item(1'b1, 8'd200, 5'd0));
        send_item(make_item(1'b0, '1, '1));
        send_item(make_item(1'b0, '0, '0));
        // one slot only: run the table dry, free two pairs, run dry again
        fill_until(ST_NEW_SLOT, 300);
        send_item(make_item(1'b1, 8'd128, 5'd0));
        send_item(make_item(1'b1, 8'd0, 5'd0));
        repeat (3) send_alloc();

        gap_pct = 88;
        write_active(32'h0000_ffff);
        random_traffic(35);
        // drop known slots from the active set; they stay in use
        write_active(32'h0000_00f0);
        random_traffic(20);
        cfg_word = $urandom;
        if (cfg_word == '0)
            cfg_word = 32'h0000_0001;
        write_active(cfg_word);
        random_traffic(20);

        gap_pct = 0;
        write_active('1);
        random_traffic(35);
        fill_until(ST_EXHAUSTED, 20);
        repeat (2) release_taken();
        repeat (3) send_alloc();

        drain();
        repeat (600) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending_answers.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
